[design/ffha_pkg.sv]
// Shared types and constants of the first-fit heap allocator.
`default_nettype none
package ffha_pkg;

	localparam int MAX_BLOCKS = 64;
	localparam int IDX_W = $clog2(MAX_BLOCKS);
	localparam int NEXT_W = IDX_W + 1;
	localparam int HEADER_BYTES = 32;
	localparam int HEADER_ALIGN = 8;
	localparam int MIN_ALIGN = 16;
	localparam int MIN_SPLIT_BYTES = 48;
	localparam int EXT_W = 36;
	localparam int HA_W = $clog2(HEADER_ALIGN);

	localparam logic [NEXT_W-1:0] NULL_IDX = NEXT_W'(MAX_BLOCKS);

	localparam logic [1:0] MODE_ALLOC = 2'd0;
	localparam logic [1:0] MODE_FREE = 2'd1;
	localparam logic [1:0] MODE_INIT = 2'd2;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_NOTHING = 3'd1;
	localparam logic [2:0] ST_BAD_ALIGN = 3'd2;
	localparam logic [2:0] ST_NO_MEM = 3'd3;
	localparam logic [2:0] ST_UNMANAGED = 3'd4;
	localparam logic [2:0] ST_BAD_RANGE = 3'd5;

	localparam logic [2:0] REG_START = 3'd0;
	localparam logic [2:0] REG_END = 3'd4;

	// One entry of the block table.
	typedef struct packed {
		logic [31:0]       bytes;
		logic              is_free;
		logic [31:0]       payload;
		logic [NEXT_W-1:0] next;
	} entry_t;

	typedef enum logic [15:0] {
		S_IDLE    = 16'h0001,
		S_A_RD    = 16'h0002,
		S_A_EV    = 16'h0004,
		S_A_FIT   = 16'h0008,
		S_A_GAP   = 16'h0010,
		S_A_SCAN  = 16'h0020,
		S_A_WR1   = 16'h0040,
		S_A_WR2   = 16'h0080,
		S_F_RD    = 16'h0100,
		S_F_EV    = 16'h0200,
		S_F_AB_RD = 16'h0400,
		S_F_AB_EV = 16'h0800,
		S_F_WR    = 16'h1000,
		S_T_RD    = 16'h2000,
		S_T_EV    = 16'h4000,
		S_DONE    = 16'h8000
	} state_t;

endpackage
`default_nettype wire

[design/first_fit_heap_allocator_top.sv]
// First-fit heap allocator with coalescing, block table held in one memory.
//
// Requests arrive on the input channel (in_valid/in_stall) with a mode and its
// operands; each request yields exactly one result beat on the output channel
// (out_valid/out_stall) carrying a status and the running statistics.
// The heap range is set through the APB registers and used only by init.
// One request is worked on at a time. Allocate walks the chain, reading and then
// checking each table entry, pads the split point, then scans slot flags one per
// cycle to find a slot for a split and writes back the split block, if any, and
// then the allocated block; free walks to the match, reads each following free
// block to merge and also joins a free block just before the match. Every
// successful request ends with a walk over the chain to rebuild the totals. All
// walks go through the single read port of the table memory.
// A result waits in the output register while the receiver stalls, and the
// next request is already accepted and worked on meanwhile.
// Reset empties the heap and clears all statistics; no clearing pass is needed
// because only entries written since the last init are ever read.
`default_nettype none
module first_fit_heap_allocator_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  mode,
	input  wire logic [31:0] request_size,
	input  wire logic [31:0] request_align,
	input  wire logic [31:0] release_address,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [2:0]  status,
	output logic      [31:0] granted_address,
	output logic      [6:0]  block_count,
	output logic      [31:0] free_total,
	output logic      [31:0] used_total,
	output logic      [31:0] alloc_count,
	output logic      [31:0] free_count
);

	localparam int EW = ffha_pkg::EXT_W;
	localparam int NW = ffha_pkg::NEXT_W;
	localparam int IW = ffha_pkg::IDX_W;
	localparam int HW = ffha_pkg::HA_W;

	ffha_pkg::state_t state_q;

	logic [31:0] start_q, end_q;
	logic [31:0] heap_base_q;
	logic [6:0]  list_len_q;
	logic [31:0] free_tot_q, used_tot_q, alloc_tot_q, rel_tot_q;
	logic [ffha_pkg::MAX_BLOCKS-1:0] slot_use_q;

	logic [NW-1:0] idx_q, prev_idx_q, steps_q, ns_q;
	logic [IW-1:0] scan_q;
	logic          split_q;
	logic [EW-1:0] addr_q, mask_q, pay_q, total_q, rem_q;
	logic [31:0]   size_q, target_q, fb_q, ub_q;
	ffha_pkg::entry_t ent_q, cur_q, prev_ent_q;
	logic [2:0]  res_status_q;
	logic [31:0] res_granted_q;

	// Table memory with a registered read port.
	ffha_pkg::entry_t mem [ffha_pkg::MAX_BLOCKS];
	ffha_pkg::entry_t rdata;
	ffha_pkg::entry_t wd;
	logic          we;
	logic [IW-1:0] wa, ra;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rdata <= mem[ra];
	end

	// APB register file.
	assign pready = 1'b1;
	assign prdata = (paddr == ffha_pkg::REG_END) ? end_q : start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			end_q <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr == ffha_pkg::REG_START) begin
				start_q <= pwdata;
			end else if (paddr == ffha_pkg::REG_END) begin
				end_q <= pwdata;
			end
		end
	end

	assign in_stall = (state_q != ffha_pkg::S_IDLE);
	logic in_acc;
	assign in_acc = in_valid && !in_stall;

	// Request decoding and init range arithmetic.
	logic        align_ok;
	logic [31:0] align_eff;
	logic [32:0] init_s, init_e;
	logic        init_bad;
	always_comb begin
		align_ok = (request_align != '0) && ((request_align & (request_align - 32'd1)) == '0);
		align_eff = (request_align < 32'(ffha_pkg::MIN_ALIGN)) ?
			32'(ffha_pkg::MIN_ALIGN) : request_align;
		init_s = ({1'b0, start_q} + 33'(ffha_pkg::HEADER_ALIGN - 1)) &
			~33'(ffha_pkg::HEADER_ALIGN - 1);
		init_e = {1'b0, end_q} & ~33'(ffha_pkg::HEADER_ALIGN - 1);
		init_bad = (start_q >= end_q) ||
			({1'b0, init_e} <= ({1'b0, init_s} + 34'(ffha_pkg::HEADER_BYTES)));
	end

	// Fit arithmetic on the registered entry.
	logic [EW-1:0] bsz, prefix, naddr, gap;
	logic [HW-1:0] gap_lo;
	logic          fits;
	always_comb begin
		bsz = EW'(ent_q.bytes);
		prefix = pay_q - addr_q;
		fits = ent_q.is_free && (prefix <= bsz) && ((bsz - prefix) >= EW'(size_q));
		naddr = addr_q + total_q;
		// Distance up to the next header boundary, taken on the low bits only.
		gap_lo = ~naddr[HW-1:0] + HW'(1);
		gap = EW'(gap_lo);
	end

	// Totals: payload of the block just read.
	logic [31:0] blk_pay;
	assign blk_pay = (rdata.bytes > 32'(ffha_pkg::HEADER_BYTES)) ?
		rdata.bytes - 32'(ffha_pkg::HEADER_BYTES) : '0;

	// Memory port control.
	always_comb begin
		we = 1'b0;
		wa = idx_q[IW-1:0];
		wd = ent_q;
		ra = idx_q[IW-1:0];
		case (state_q)
			ffha_pkg::S_IDLE: begin
				we = in_acc && (mode == ffha_pkg::MODE_INIT) && !init_bad;
				wa = '0;
				wd = '{bytes: 32'(init_e - init_s), is_free: 1'b1, payload: '0,
					next: ffha_pkg::NULL_IDX};
			end
			ffha_pkg::S_A_WR1: begin
				we = 1'b1;
				wa = ns_q[IW-1:0];
				wd = '{bytes: rem_q[31:0], is_free: 1'b1, payload: '0, next: ent_q.next};
			end
			ffha_pkg::S_A_WR2: begin
				we = 1'b1;
				wd = '{bytes: split_q ? total_q[31:0] : ent_q.bytes, is_free: 1'b0,
					payload: pay_q[31:0], next: split_q ? ns_q : ent_q.next};
			end
			ffha_pkg::S_F_AB_RD: begin
				ra = cur_q.next[IW-1:0];
			end
			ffha_pkg::S_F_WR: begin
				we = 1'b1;
				if ((prev_idx_q != ffha_pkg::NULL_IDX) && prev_ent_q.is_free) begin
					wa = prev_idx_q[IW-1:0];
					wd = '{bytes: prev_ent_q.bytes + cur_q.bytes, is_free: 1'b1,
						payload: prev_ent_q.payload, next: cur_q.next};
				end else begin
					wd = cur_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffha_pkg::S_IDLE;
			heap_base_q <= '0;
			list_len_q <= '0;
			free_tot_q <= '0;
			used_tot_q <= '0;
			alloc_tot_q <= '0;
			rel_tot_q <= '0;
			slot_use_q <= '0;
			out_valid <= 1'b0;
		end else begin
			// The result register empties once its beat is taken, unless a new
			// result is loaded in the same cycle.
			if (out_valid && !out_stall && (state_q != ffha_pkg::S_DONE)) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ffha_pkg::S_IDLE: begin
					if (in_acc) begin
						res_granted_q <= '0;
						size_q <= request_size;
						target_q <= release_address;
						mask_q <= EW'(align_eff - 32'd1);
						addr_q <= EW'(heap_base_q);
						idx_q <= '0;
						steps_q <= '0;
						prev_idx_q <= ffha_pkg::NULL_IDX;
						state_q <= ffha_pkg::S_DONE;
						if (mode == ffha_pkg::MODE_ALLOC) begin
							if (request_size == '0) begin
								res_status_q <= ffha_pkg::ST_NOTHING;
							end else if (!align_ok) begin
								res_status_q <= ffha_pkg::ST_BAD_ALIGN;
							end else if (list_len_q == '0) begin
								res_status_q <= ffha_pkg::ST_NO_MEM;
							end else begin
								state_q <= ffha_pkg::S_A_RD;
							end
						end else if (mode == ffha_pkg::MODE_FREE) begin
							if (release_address == '0) begin
								res_status_q <= ffha_pkg::ST_NOTHING;
							end else if (list_len_q == '0) begin
								res_status_q <= ffha_pkg::ST_UNMANAGED;
							end else begin
								state_q <= ffha_pkg::S_F_RD;
							end
						end else if (mode == ffha_pkg::MODE_INIT) begin
							if (init_bad) begin
								res_status_q <= ffha_pkg::ST_BAD_RANGE;
							end else begin
								res_status_q <= ffha_pkg::ST_OK;
								heap_base_q <= init_s[31:0];
								slot_use_q <= ffha_pkg::MAX_BLOCKS'(1);
								alloc_tot_q <= '0;
								rel_tot_q <= '0;
								fb_q <= '0;
								ub_q <= '0;
								state_q <= ffha_pkg::S_T_RD;
							end
						end else begin
							res_status_q <= ffha_pkg::ST_NOTHING;
						end
					end
				end
				ffha_pkg::S_A_RD: begin
					state_q <= ffha_pkg::S_A_EV;
				end
				ffha_pkg::S_A_EV: begin
					ent_q <= rdata;
					pay_q <= (addr_q + EW'(ffha_pkg::HEADER_BYTES) + mask_q) & ~mask_q;
					state_q <= ffha_pkg::S_A_FIT;
				end
				ffha_pkg::S_A_FIT: begin
					if (fits) begin
						total_q <= prefix + EW'(size_q);
						rem_q <= bsz - prefix - EW'(size_q);
						state_q <= ffha_pkg::S_A_GAP;
					end else if ((ent_q.next >= ffha_pkg::NULL_IDX) ||
						(steps_q == NW'(ffha_pkg::MAX_BLOCKS - 1))) begin
						res_status_q <= ffha_pkg::ST_NO_MEM;
						state_q <= ffha_pkg::S_DONE;
					end else begin
						addr_q <= addr_q + bsz;
						idx_q <= ent_q.next;
						steps_q <= steps_q + 1'b1;
						state_q <= ffha_pkg::S_A_RD;
					end
				end
				ffha_pkg::S_A_GAP: begin
					// Raise the split point to a header boundary.
					if ((rem_q != '0) && (gap != '0)) begin
						if (rem_q <= gap) begin
							rem_q <= '0;
						end else begin
							total_q <= total_q + gap;
							rem_q <= rem_q - gap;
						end
					end
					scan_q <= '0;
					split_q <= 1'b0;
					state_q <= ffha_pkg::S_A_SCAN;
				end
				ffha_pkg::S_A_SCAN: begin
					// Look for an unused slot, one per cycle.
					if (rem_q < EW'(ffha_pkg::MIN_SPLIT_BYTES)) begin
						state_q <= ffha_pkg::S_A_WR2;
					end else if (!slot_use_q[scan_q]) begin
						ns_q <= NW'(scan_q);
						split_q <= 1'b1;
						state_q <= ffha_pkg::S_A_WR1;
					end else if (scan_q == IW'(ffha_pkg::MAX_BLOCKS - 1)) begin
						state_q <= ffha_pkg::S_A_WR2;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ffha_pkg::S_A_WR1: begin
					slot_use_q[ns_q[IW-1:0]] <= 1'b1;
					state_q <= ffha_pkg::S_A_WR2;
				end
				ffha_pkg::S_A_WR2: begin
					alloc_tot_q <= alloc_tot_q + 32'd1;
					res_granted_q <= pay_q[31:0];
					res_status_q <= ffha_pkg::ST_OK;
					idx_q <= '0;
					fb_q <= '0;
					ub_q <= '0;
					steps_q <= '0;
					state_q <= ffha_pkg::S_T_RD;
				end
				ffha_pkg::S_F_RD: begin
					state_q <= ffha_pkg::S_F_EV;
				end
				ffha_pkg::S_F_EV: begin
					if (!rdata.is_free && (rdata.payload == target_q)) begin
						rel_tot_q <= rel_tot_q + 32'd1;
						cur_q <= '{bytes: rdata.bytes, is_free: 1'b1, payload: '0,
							next: rdata.next};
						state_q <= (rdata.next >= ffha_pkg::NULL_IDX) ?
							ffha_pkg::S_F_WR : ffha_pkg::S_F_AB_RD;
					end else if ((rdata.next >= ffha_pkg::NULL_IDX) ||
						(steps_q == NW'(ffha_pkg::MAX_BLOCKS - 1))) begin
						res_status_q <= ffha_pkg::ST_UNMANAGED;
						state_q <= ffha_pkg::S_DONE;
					end else begin
						prev_idx_q <= idx_q;
						prev_ent_q <= rdata;
						idx_q <= rdata.next;
						steps_q <= steps_q + 1'b1;
						state_q <= ffha_pkg::S_F_RD;
					end
				end
				ffha_pkg::S_F_AB_RD: begin
					state_q <= ffha_pkg::S_F_AB_EV;
				end
				ffha_pkg::S_F_AB_EV: begin
					// Absorb the following block while it is free.
					if (rdata.is_free) begin
						cur_q.bytes <= cur_q.bytes + rdata.bytes;
						cur_q.next <= rdata.next;
						slot_use_q[cur_q.next[IW-1:0]] <= 1'b0;
						state_q <= (rdata.next >= ffha_pkg::NULL_IDX) ?
							ffha_pkg::S_F_WR : ffha_pkg::S_F_AB_RD;
					end else begin
						state_q <= ffha_pkg::S_F_WR;
					end
				end
				ffha_pkg::S_F_WR: begin
					if ((prev_idx_q != ffha_pkg::NULL_IDX) && prev_ent_q.is_free) begin
						slot_use_q[idx_q[IW-1:0]] <= 1'b0;
					end
					res_status_q <= ffha_pkg::ST_OK;
					idx_q <= '0;
					fb_q <= '0;
					ub_q <= '0;
					steps_q <= '0;
					state_q <= ffha_pkg::S_T_RD;
				end
				ffha_pkg::S_T_RD: begin
					state_q <= ffha_pkg::S_T_EV;
				end
				ffha_pkg::S_T_EV: begin
					// Walk the chain to rebuild the totals.
					if ((rdata.next >= ffha_pkg::NULL_IDX) ||
						(steps_q == NW'(ffha_pkg::MAX_BLOCKS - 1))) begin
						list_len_q <= 7'(steps_q + 1'b1);
						free_tot_q <= rdata.is_free ? fb_q + blk_pay : fb_q;
						used_tot_q <= rdata.is_free ? ub_q : ub_q + blk_pay;
						state_q <= ffha_pkg::S_DONE;
					end else begin
						if (rdata.is_free) begin
							fb_q <= fb_q + blk_pay;
						end else begin
							ub_q <= ub_q + blk_pay;
						end
						steps_q <= steps_q + 1'b1;
						idx_q <= rdata.next;
						state_q <= ffha_pkg::S_T_RD;
					end
				end
				ffha_pkg::S_DONE: begin
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						status <= res_status_q;
						granted_address <= res_granted_q;
						block_count <= list_len_q;
						free_total <= free_tot_q;
						used_total <= used_tot_q;
						alloc_count <= alloc_tot_q;
						free_count <= rel_tot_q;
						state_q <= ffha_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= ffha_pkg::S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

[tb/tb_first_fit_heap_allocator_top.sv]
// Self-checking testbench for the first-fit heap allocator: directed table, then random traffic.
`default_nettype none
module tb_first_fit_heap_allocator_top;
	timeunit 1ns;
	timeprecision 1ps;

	// One request beat and one result beat.
	typedef struct {
		logic [1:0]  mode;
		logic [31:0] size;
		logic [31:0] align;
		logic [31:0] rel;
	} req_t;

	typedef struct {
		logic [2:0]  status;
		logic [31:0] granted;
		logic [6:0]  count;
		logic [31:0] fbytes;
		logic [31:0] ubytes;
		logic [31:0] allocs;
		logic [31:0] frees;
	} res_t;

	// Directed row: optional heap range write, the request, an optional typed status,
	// and a flag to release the oldest live allocation instead of rel.
	typedef struct {
		bit          wr_cfg;
		logic [31:0] cfg_start;
		logic [31:0] cfg_end;
		req_t        req;
		bit          typed;
		logic [2:0]  status;
		bit          pick_live;
	} row_t;

	localparam int WATCHDOG_CYCLES = 20000;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_ITEMS = 150;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	bit clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] mode = '0;
	logic [31:0] request_size = '0, request_align = '0, release_address = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [2:0] status;
	logic [31:0] granted_address, free_total, used_total, alloc_count, free_count;
	logic [6:0] block_count;

	first_fit_heap_allocator_top dut (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// Predictor state: the block table, statistics and the configured range.
	logic [31:0] h_bytes [ffha_pkg::MAX_BLOCKS];
	bit          h_free [ffha_pkg::MAX_BLOCKS];
	logic [31:0] h_pay [ffha_pkg::MAX_BLOCKS];
	int          h_next [ffha_pkg::MAX_BLOCKS];
	bit          h_used [ffha_pkg::MAX_BLOCKS];
	int unsigned h_len;
	logic [31:0] h_fb, h_ub, h_allocs, h_frees, h_base;
	logic [31:0] cfg_start_q, cfg_end_q;

	res_t expected_results[$];
	logic [31:0] live_payloads[$];
	int mismatches = 0;
	bit quiet = 0;

	function automatic longint unsigned rnd_up(longint unsigned x, longint unsigned a);
		return ((x + a - 1) / a) * a;
	endfunction

	function automatic void heap_clear();
		for (int i = 0; i < ffha_pkg::MAX_BLOCKS; i++) begin
			h_bytes[i] = '0;
			h_free[i] = 0;
			h_pay[i] = '0;
			h_next[i] = ffha_pkg::MAX_BLOCKS;
			h_used[i] = 0;
		end
	endfunction

	function automatic void heap_totals();
		int idx;
		int unsigned cnt;
		logic [31:0] fb, ub, pay;
		idx = h_len ? 0 : ffha_pkg::MAX_BLOCKS;
		cnt = 0;
		fb = '0;
		ub = '0;
		while (idx < ffha_pkg::MAX_BLOCKS && cnt < ffha_pkg::MAX_BLOCKS) begin
			pay = h_bytes[idx] > ffha_pkg::HEADER_BYTES ?
				h_bytes[idx] - ffha_pkg::HEADER_BYTES : '0;
			if (h_free[idx]) fb += pay; else ub += pay;
			cnt++;
			idx = h_next[idx];
		end
		h_len = cnt;
		h_fb = fb;
		h_ub = ub;
	endfunction

	function automatic logic [2:0] heap_init();
		longint unsigned s, e;
		if (cfg_start_q >= cfg_end_q) return ffha_pkg::ST_BAD_RANGE;
		s = rnd_up(cfg_start_q, ffha_pkg::HEADER_ALIGN);
		e = (cfg_end_q / ffha_pkg::HEADER_ALIGN) * ffha_pkg::HEADER_ALIGN;
		if (e <= s + ffha_pkg::HEADER_BYTES) return ffha_pkg::ST_BAD_RANGE;
		heap_clear();
		h_base = s[31:0];
		h_used[0] = 1;
		h_bytes[0] = 32'(e - s);
		h_free[0] = 1;
		h_len = 1;
		h_allocs = '0;
		h_frees = '0;
		return ffha_pkg::ST_OK;
	endfunction

	function automatic logic [2:0] heap_alloc(logic [31:0] size, logic [31:0] align,
			output logic [31:0] g);
		longint unsigned a, addr, bsz, pay, prefix, total, rem, naddr, gap;
		int idx, steps, ns;
		g = '0;
		addr = h_base;
		if (size == 0) return ffha_pkg::ST_NOTHING;
		if (align == 0 || (align & (align - 1)) != 0) return ffha_pkg::ST_BAD_ALIGN;
		a = align < ffha_pkg::MIN_ALIGN ? ffha_pkg::MIN_ALIGN : align;
		idx = h_len ? 0 : ffha_pkg::MAX_BLOCKS;
		steps = 0;
		while (idx < ffha_pkg::MAX_BLOCKS && steps < ffha_pkg::MAX_BLOCKS) begin
			bsz = h_bytes[idx];
			steps++;
			if (h_free[idx]) begin
				pay = rnd_up(addr + ffha_pkg::HEADER_BYTES, a);
				prefix = pay - addr;
				if (prefix <= bsz && bsz - prefix >= size) begin
					total = prefix + size;
					rem = bsz - total;
					naddr = addr + total;
					// Pad the split point up to header alignment.
					if (rem > 0) begin
						gap = rnd_up(naddr, ffha_pkg::HEADER_ALIGN) - naddr;
						if (gap > 0) begin
							if (rem <= gap) rem = 0;
							else begin
								total += gap;
								rem -= gap;
							end
						end
					end
					if (rem >= ffha_pkg::MIN_SPLIT_BYTES) begin
						ns = ffha_pkg::MAX_BLOCKS;
						for (int i = ffha_pkg::MAX_BLOCKS - 1; i >= 0; i--)
							if (!h_used[i]) ns = i;
						if (ns < ffha_pkg::MAX_BLOCKS) begin
							h_used[ns] = 1;
							h_bytes[ns] = 32'(rem);
							h_free[ns] = 1;
							h_pay[ns] = '0;
							h_next[ns] = h_next[idx];
							h_next[idx] = ns;
							h_bytes[idx] = 32'(total);
						end
					end
					h_free[idx] = 0;
					h_pay[idx] = 32'(pay);
					h_allocs++;
					g = 32'(pay);
					return ffha_pkg::ST_OK;
				end
			end
			addr += bsz;
			idx = h_next[idx];
		end
		return ffha_pkg::ST_NO_MEM;
	endfunction

	function automatic void heap_merge_next(int idx);
		int n;
		n = h_next[idx];
		while (n < ffha_pkg::MAX_BLOCKS && h_free[n]) begin
			h_bytes[idx] += h_bytes[n];
			h_next[idx] = h_next[n];
			h_used[n] = 0;
			h_next[n] = ffha_pkg::MAX_BLOCKS;
			h_bytes[n] = '0;
			h_free[n] = 0;
			n = h_next[idx];
		end
	endfunction

	function automatic logic [2:0] heap_release(logic [31:0] target);
		int prev, idx, steps;
		prev = ffha_pkg::MAX_BLOCKS;
		idx = h_len ? 0 : ffha_pkg::MAX_BLOCKS;
		steps = 0;
		if (target == 0) return ffha_pkg::ST_NOTHING;
		while (idx < ffha_pkg::MAX_BLOCKS && steps < ffha_pkg::MAX_BLOCKS) begin
			steps++;
			if (!h_free[idx] && h_pay[idx] == target) begin
				h_frees++;
				h_free[idx] = 1;
				h_pay[idx] = '0;
				heap_merge_next(idx);
				if (prev < ffha_pkg::MAX_BLOCKS && h_free[prev]) heap_merge_next(prev);
				return ffha_pkg::ST_OK;
			end
			prev = idx;
			idx = h_next[idx];
		end
		return ffha_pkg::ST_UNMANAGED;
	endfunction

	// Work out the result of one request and track which payloads are live.
	function automatic res_t heap_predict(req_t r);
		res_t o;
		logic [31:0] g;
		g = '0;
		case (r.mode)
			ffha_pkg::MODE_ALLOC: o.status = heap_alloc(r.size, r.align, g);
			ffha_pkg::MODE_FREE: o.status = heap_release(r.rel);
			ffha_pkg::MODE_INIT: o.status = heap_init();
			default: o.status = ffha_pkg::ST_NOTHING;
		endcase
		if (o.status == ffha_pkg::ST_OK) begin
			heap_totals();
			if (r.mode == ffha_pkg::MODE_ALLOC) live_payloads.push_back(g);
			else if (r.mode == ffha_pkg::MODE_INIT) live_payloads.delete();
			else
				foreach (live_payloads[i])
					if (live_payloads[i] == r.rel) begin
						live_payloads.delete(i);
						break;
					end
		end
		o.granted = g;
		o.count = h_len[6:0];
		o.fbytes = h_fb;
		o.ubytes = h_ub;
		o.allocs = h_allocs;
		o.frees = h_frees;
		return o;
	endfunction

	// Send one request beat; valid stays high into the next beat unless a gap is drawn.
	task automatic send_request(req_t r, bit typed, logic [2:0] typed_status);
		res_t e;
		if (!quiet && $urandom_range(99) < 18) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		mode <= r.mode;
		request_size <= r.size;
		request_align <= r.align;
		release_address <= r.rel;
		in_valid <= 1;
		do @(posedge clk); while (in_stall !== 1'b0);
		e = heap_predict(r);
		if (typed) e.status = typed_status;
		expected_results.push_back(e);
	endtask

	// Drop valid and wait until every result is in before touching registers.
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic reg_write(logic [2:0] addr, logic [31:0] data);
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic set_range(logic [31:0] s, logic [31:0] e);
		drain();
		reg_write(ffha_pkg::REG_START, s);
		reg_write(ffha_pkg::REG_END, e);
		cfg_start_q = s;
		cfg_end_q = e;
	endtask

	function automatic logic [31:0] pick_align();
		int r;
		r = $urandom_range(99);
		if (r < 70) return 32'd1 << $urandom_range(0, 6);
		if (r < 82) return 32'd1 << $urandom_range(0, 31);
		if (r < 92) return $urandom;
		return '0;
	endfunction

	// Mostly allocate and release of live payloads, with some noise.
	function automatic req_t random_request(bit tiny);
		req_t r;
		int k, s;
		k = $urandom_range(99);
		s = $urandom_range(99);
		r.mode = ffha_pkg::MODE_ALLOC;
		r.size = $urandom;
		r.align = pick_align();
		r.rel = $urandom;
		if (k < 48) begin
			if (s < 85) r.size = $urandom_range(1, tiny ? 24 : 400);
			else if (s < 93) r.size = '0;
		end else if (k < 88) begin
			r.mode = ffha_pkg::MODE_FREE;
			if (live_payloads.size() != 0 && s < 80)
				r.rel = live_payloads[$urandom_range(0, live_payloads.size() - 1)];
			else if (s < 88) r.rel = '0;
		end else if (k < 92) r.mode = ffha_pkg::MODE_INIT;
		else if (k < 96) r.mode = MODE_UNUSED;
		return r;
	endfunction

	row_t rows[$];

	initial begin
		row_t w;
		logic [31:0] s;
		heap_clear();
		h_len = 0;
		h_fb = '0;
		h_ub = '0;
		h_allocs = '0;
		h_frees = '0;
		h_base = '0;
		cfg_start_q = '0;
		cfg_end_q = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed rows.
		rows = '{
			'{0, 0, 0, '{ffha_pkg::MODE_ALLOC, 16, 16, 0}, 1, ffha_pkg::ST_NO_MEM, 0},
			'{0, 0, 0, '{ffha_pkg::MODE_FREE, 0, 0, 0}, 1, ffha_pkg::ST_NOTHING, 0},
			'{0, 0, 0, '{ffha_pkg::MODE_FREE, 0, 0, 32'h40}, 1, ffha_pkg::ST_UNMANAGED, 0},
			'{0, 0, 0, '{MODE_UNUSED, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
				1, ffha_pkg::ST_NOTHING, 0},
			'{0, 0, 0, '{ffha_pkg::MODE_INIT, 0, 0, 0}, 1, ffha_pkg::ST_BAD_RANGE, 0},
			'{1, 32'h1000, 32'h1000, '{ffha_pkg::MODE_INIT, 0, 0, 0},
				1, ffha_pkg::ST_BAD_RANGE, 0},
			'{1, 32'h1003, 32'h1028, '{ffha_pkg::MODE_INIT, 0, 0, 0},
				1, ffha_pkg::ST_BAD_RANGE, 0},
			'{1, 32'h0, 32'hFFFFFFFF, '{ffha_pkg::MODE_INIT, 0, 0, 0}, 1, ffha_pkg::ST_OK, 0},
			'{0, 0, 0, '{ffha_pkg::MODE_ALLOC, 32'hFFFFFFFF, 1, 0}, 1, ffha_pkg::ST_NO_MEM, 0},
			'{0, 0, 0, '{ffha_pkg::MODE_ALLOC, 0, 16, 0}, 1, ffha_pkg::ST_NOTHING, 0},
			'{0, 0, 0, '{ffha_pkg::MODE_ALLOC, 0, 0, 0}, 1, ffha_pkg::ST_NOTHING, 0},
			'{0, 0, 0, '{ffha_pkg::MODE_ALLOC, 5, 0, 0}, 1, ffha_pkg::ST_BAD_ALIGN, 0},
			'{0, 0, 0, '{ffha_pkg::MODE_ALLOC, 5, 6, 0}, 1, ffha_pkg::ST_BAD_ALIGN, 0},
			'{0, 0, 0, '{ffha_pkg::MODE_ALLOC, 5, 32'h80000000, 0}, 0, 0, 0},
			'{0, 0, 0, '{ffha_pkg::MODE_ALLOC, 32'hFFFFFF00, 16, 0}, 0, 0, 0},
			'{0, 0, 0, '{ffha_pkg::MODE_FREE, 0, 0, 32'hFFFFFFFF},
				1, ffha_pkg::ST_UNMANAGED, 0},
			'{1, 32'h101, 32'h407, '{ffha_pkg::MODE_INIT, 0, 0, 0}, 0, 0, 0},
			'{0, 0, 0, '{ffha_pkg::MODE_ALLOC, 1, 1, 0}, 0, 0, 0},
			'{0, 0, 0, '{ffha_pkg::MODE_ALLOC, 13, 32, 0}, 0, 0, 0},
			'{0, 0, 0, '{ffha_pkg::MODE_ALLOC, 40, 8, 0}, 0, 0, 0},
			'{0, 0, 0, '{ffha_pkg::MODE_ALLOC, 600, 64, 0}, 0, 0, 0},
			'{0, 0, 0, '{ffha_pkg::MODE_FREE, 0, 0, 0}, 0, 0, 1},
			'{0, 0, 0, '{ffha_pkg::MODE_FREE, 0, 0, 0}, 0, 0, 1},
			'{0, 0, 0, '{ffha_pkg::MODE_FREE, 0, 0, 0}, 0, 0, 1}
		};
		foreach (rows[i]) begin
			w = rows[i];
			if (w.wr_cfg) set_range(w.cfg_start, w.cfg_end);
			if (w.pick_live && live_payloads.size() != 0) w.req.rel = live_payloads[0];
			send_request(w.req, w.typed, w.status);
		end

		// Random phases, each setting the heap range anew; some small enough to fill the table.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			s = $urandom;
			case (p % 4)
				0: set_range(s, s + $urandom_range(256, 6000));
				1: set_range(s & 32'h000FFFFF, (s & 32'h000FFFFF) + $urandom_range(1500, 4200));
				2: set_range(p == 2 ? 32'hFFFFF000 : s, p == 2 ? 32'hFFFFFFFF : $urandom);
				default: set_range(32'h0, 32'hFFFFFFFF);
			endcase
			send_request(req_t'{ffha_pkg::MODE_INIT, $urandom, $urandom, $urandom}, 0, 0);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				quiet = (p == 5);
				send_request(random_request(p % 4 == 1), 0, 0);
			end
		end
		quiet = 0;
		in_valid <= 0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

	// Receiver stalls at random, except during the quiet phase.
	always @(posedge clk)
		out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 18);

	// Compare every result beat with the oldest expectation.
	always @(posedge clk) begin
		res_t e;
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Result beat with nothing expected");
			end else begin
				e = expected_results.pop_front();
				if (status !== e.status || granted_address !== e.granted
						|| block_count !== e.count || free_total !== e.fbytes
						|| used_total !== e.ubytes || alloc_count !== e.allocs
						|| free_count !== e.frees) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Mismatch: exp st=%0d g=%h n=%0d fb=%0d ub=%0d a=%0d f=%0d",
							e.status, e.granted, e.count, e.fbytes, e.ubytes, e.allocs,
							e.frees);
						$display("          got st=%0d g=%h n=%0d fb=%0d ub=%0d a=%0d f=%0d",
							status, granted_address, block_count, free_total,
							used_total, alloc_count, free_count);
					end
				end
			end
		end
	end

	// Watchdog: too long without any beat on either channel ends the run.
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_stall === 1'b0)
				|| (out_valid === 1'b1 && out_stall === 1'b0))
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

endmodule
`default_nettype wire

[first_fit_heap_allocator_top.f]
design/ffha_pkg.sv
design/first_fit_heap_allocator_top.sv
tb/tb_first_fit_heap_allocator_top.sv
